FILE: rtl/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_W    = 16;
    localparam int SLOT_W    = 3;
    localparam int CFG_W     = 4;
    localparam int COUNT_W   = 32;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [COUNT_W-1:0] t_count;

    // Outcome of one lookup; exactly one of the three is set
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
    } t_lookup;

endpackage

`default_nettype wire

FILE: rtl/lrupr_if.sv
`default_nettype none

interface lrupr_ref_if;
    import lrupr_pkg::*;
    logic  valid;
    logic  ready;
    t_page page_number;
    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_res_if;
    import lrupr_pkg::*;
    logic   valid;
    logic   ready;
    logic   hit;
    t_slot  frame_slot;
    logic   evicted_valid;
    t_page  evicted_page;
    t_count fault_count;
    modport source (output valid, output hit, output frame_slot, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

interface lrupr_cfg_if;
    import lrupr_pkg::*;
    logic valid;
    logic ready;
    t_cfg frames_in_use;
    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrupr_core.sv
`default_nettype none

module lrupr_core #(
    parameter int FRAMES = 8,
    parameter int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  lrupr_pkg::t_page   i_page,
    input  lrupr_pkg::t_page   i_frame_page [FRAMES],
    input  logic [FRAMES-1:0]  i_valid,
    input  logic [IW-1:0]      i_rank [FRAMES],
    input  logic [FRAMES-1:0]  i_active,
    input  logic [IW-1:0]      i_oldest_rank,
    output lrupr_pkg::t_lookup o_status,
    output logic [IW-1:0]      o_slot,
    output lrupr_pkg::t_page   o_evicted_page,
    output logic [FRAMES-1:0]  o_valid_next,
    output logic [IW-1:0]      o_rank_next [FRAMES]
);
    import lrupr_pkg::*;

    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] empty;
    logic [FRAMES-1:0] oldest;
    logic [IW-1:0]     hit_slot;
    logic [IW-1:0]     empty_slot;
    logic [IW-1:0]     victim_slot;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     slot_rank;

    // Lowest index wins in every search
    always_comb begin
        hit_slot    = '0;
        empty_slot  = '0;
        victim_slot = '0;
        for (int i = 0; i < FRAMES; i++) begin
            match[i]  = i_valid[i] && i_active[i] && (i_frame_page[i] == i_page);
            empty[i]  = !i_valid[i] && i_active[i];
            oldest[i] = i_valid[i] && i_active[i] && (i_rank[i] == i_oldest_rank);
        end
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i])  hit_slot    = IW'(i);
            if (empty[i])  empty_slot  = IW'(i);
            if (oldest[i]) victim_slot = IW'(i);
        end
    end

    always_comb begin
        o_status.hit   = |match;
        o_status.fill  = !(|match) && (|empty);
        o_status.evict = !(|match) && !(|empty);
        if (o_status.hit) begin
            slot = hit_slot;
        end else if (o_status.fill) begin
            slot = empty_slot;
        end else begin
            slot = victim_slot;
        end
        slot_rank = i_rank[slot];
    end

    // Age every valid frame younger than the touched one; on a miss age them all
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            if (IW'(i) == slot) begin
                o_rank_next[i] = '0;
            end else if (i_valid[i] && i_active[i]
                         && (!o_status.hit || (i_rank[i] < slot_rank))) begin
                o_rank_next[i] = i_rank[i] + 1'b1;
            end else begin
                o_rank_next[i] = i_rank[i];
            end
            o_valid_next[i] = i_valid[i] || (IW'(i) == slot);
        end
    end

    assign o_slot         = slot;
    assign o_evicted_page = o_status.evict ? i_frame_page[slot] : '0;

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
`default_nettype none

// LRU page replacement unit.
// i_ref carries one page reference per beat; o_res returns one result beat per
// reference, in order: hit flag, frame slot, evicted page (zero when none) and
// the saturating fault total. i_cfg writes frames_in_use (0 acts as 1, above
// FRAMES acts as FRAMES) and flushes every frame; the fault total is kept.
// Write the register only while the unit is empty; i_cfg.ready is always high.
// Throughput: one reference per clock while o_res is not stalled. The tag
// compare over all active frames, the victim pick and the rank update sit
// between the reference register and the result register, so back-to-back
// references see each other's updates with no bubble.
// An accepted reference moves from the reference register to the result
// register, which offers it on o_res. A stalled o_res holds its beat; the
// reference register keeps accepting until it is full, then i_ref.ready drops.
// Reset: all frames empty, ranks zero, fault total zero, frames_in_use 8
// (capped at FRAMES). No clearing pass; the page store is only read where a
// frame is marked valid.
module lru_page_replacement #(
    parameter int FRAMES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrupr_ref_if.sink   i_ref,
    lrupr_cfg_if.sink   i_cfg,
    lrupr_res_if.source o_res
);
    import lrupr_pkg::*;

    localparam int IW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RESET_N = (int'(CFG_RESET) > FRAMES) ? FRAMES : int'(CFG_RESET);

    // Active frame mask for a given count of frames
    function automatic logic [FRAMES-1:0] mask_of(input int n);
        logic [FRAMES-1:0] m;
        for (int i = 0; i < FRAMES; i++) begin
            m[i] = (i < n);
        end
        return m;
    endfunction

    // Clamp the written frame count into 1..FRAMES
    function automatic int clamp_frames(input t_cfg v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > FRAMES) n = FRAMES;
        return n;
    endfunction

    // configuration
    logic [FRAMES-1:0] r_active;
    logic [IW-1:0]     r_oldest_rank;

    // frame state
    t_page             r_frame_page [FRAMES];
    logic [FRAMES-1:0] r_valid;
    logic [IW-1:0]     r_rank [FRAMES];
    t_count            r_fault_total;

    // reference register
    logic  r_s1_valid;
    t_page r_s1_page;

    // result register
    logic   r_out_valid;
    logic   r_out_hit;
    t_slot  r_out_slot;
    logic   r_out_ev_valid;
    t_page  r_out_ev_page;
    t_count r_out_fault;

    // lookup results
    t_lookup           st;
    logic [IW-1:0]     slot;
    t_page             ev_page;
    logic [FRAMES-1:0] n_valid;
    logic [IW-1:0]     n_rank [FRAMES];
    t_count            n_fault_total;

    logic in_fire;
    logic s1_fire;
    logic cfg_fire;

    // Advance the reference register whenever the result register frees up
    assign s1_fire  = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_fire  = i_ref.valid && i_ref.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_ref.ready = !r_s1_valid || s1_fire;
    assign i_cfg.ready = 1'b1;

    lrupr_core #(
        .FRAMES (FRAMES),
        .IW     (IW)
    ) u_core (
        .i_page         (r_s1_page),
        .i_frame_page   (r_frame_page),
        .i_valid        (r_valid),
        .i_rank         (r_rank),
        .i_active       (r_active),
        .i_oldest_rank  (r_oldest_rank),
        .o_status       (st),
        .o_slot         (slot),
        .o_evicted_page (ev_page),
        .o_valid_next   (n_valid),
        .o_rank_next    (n_rank)
    );

    // Count every miss, cold fills too; hold at all ones
    assign n_fault_total = (!st.hit && (r_fault_total != '1)) ? r_fault_total + 1'b1
                                                               : r_fault_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= mask_of(RESET_N);
            r_oldest_rank <= IW'(RESET_N - 1);
            r_valid       <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
            r_fault_total <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_fire) begin
                // flush all frames, keep the fault total
                r_active      <= mask_of(clamp_frames(i_cfg.frames_in_use));
                r_oldest_rank <= IW'(clamp_frames(i_cfg.frames_in_use) - 1);
                r_valid       <= '0;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end else if (s1_fire) begin
                r_valid       <= n_valid;
                r_rank        <= n_rank;
                r_fault_total <= n_fault_total;
            end

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: page store, reference and result registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_page <= i_ref.page_number;
        end
        if (s1_fire && !st.hit) begin
            r_frame_page[slot] <= r_s1_page;
        end
        if (s1_fire) begin
            r_out_hit      <= st.hit;
            r_out_slot     <= SLOT_W'(slot);
            r_out_ev_valid <= st.evict;
            r_out_ev_page  <= ev_page;
            r_out_fault    <= n_fault_total;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.hit           = r_out_hit;
    assign o_res.frame_slot    = r_out_slot;
    assign o_res.evicted_valid = r_out_ev_valid;
    assign o_res.evicted_page  = r_out_ev_page;
    assign o_res.fault_count   = r_out_fault;

    // No frame outside the active set ever holds a page
    a_valid_in_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid & ~r_active) == '0)
        else $error("frame valid outside active set");

    // A hit leaves the fault total alone
    a_hit_keeps_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && st.hit && !cfg_fire |=> $stable(r_fault_total))
        else $error("fault total moved on a hit");

    // The touched frame ends up valid and most recent
    a_touch_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !cfg_fire |=> r_valid[$past(slot)] && (r_rank[$past(slot)] == '0))
        else $error("touched frame not newest");

    // A configuration write empties every frame
    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (r_valid == '0))
        else $error("frames not flushed after config write");

    // A result is either a hit or a fault, never an eviction on a hit
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_ev_valid))
        else $error("eviction reported on a hit");

endmodule

`default_nettype wire

FILE: test/tb_lru_page_replacement.sv
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int FRAMES         = 8;
    localparam int LONG_STALL     = 120;   // receiver hold-off, long enough to back up i_ref
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int PHASES         = 12;

    // frame counts for the random part; 0 and 15 probe the clamping on both ends
    localparam t_cfg SWEEP [PHASES] = '{4'd8, 4'd3, 4'd1, 4'd5, 4'd0, 4'd12,
                                        4'd2, 4'd7, 4'd15, 4'd4, 4'd6, 4'd8};

    // One result beat as the unit should produce it
    typedef struct packed {
        logic   hit;
        t_slot  frame_slot;
        logic   evicted_valid;
        t_page  evicted_page;
        t_count fault_count;
    } t_ref_outcome;

    logic clk = 1'b0;
    logic rst_n;

    lrupr_ref_if ref_ch ();
    lrupr_cfg_if cfg_ch ();
    lrupr_res_if res_ch ();

    lru_page_replacement #(
        .FRAMES (FRAMES)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ref   (ref_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the replacement state
    // ------------------------------------------------------------------
    t_page    frame_page [FRAMES];
    bit       frame_live [FRAMES];
    bit [2:0] frame_rank [FRAMES];   // 0 = most recently used
    t_count   fault_total;
    t_cfg     frame_setting;

    t_page        refs_to_send [$];       // page references waiting for the driver
    t_ref_outcome expected_outcomes [$];  // outcomes of accepted references, oldest first

    int mismatch_count = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int cfg_writes     = 0;

    // idle knobs, changed per phase from the stimulus process
    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;
    int long_stall_reqs = 0;

    // Clamp the register to the number of frames that take part
    function automatic int active_count(input t_cfg setting);
        if (setting == 0)
            return 1;
        if (setting > FRAMES)
            return FRAMES;
        return int'(setting);
    endfunction

    // Apply a frame-count write: every frame is emptied, the fault total survives
    function automatic void set_frame_count(input t_cfg setting);
        frame_setting = setting;
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_live[i] = 1'b0;
            frame_rank[i] = '0;
        end
    endfunction

    // Look one page up, replace on a miss, and return the outcome it must produce
    function automatic t_ref_outcome lookup_and_replace(input t_page pg);
        t_ref_outcome o;
        int  n;
        int  slot;
        int  limit;
        bit  found;
        o     = '0;
        n     = active_count(frame_setting);
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && frame_live[i] && frame_page[i] == pg) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            // hit: only frames younger than this one grow older
            o.hit = 1'b1;
            limit = frame_rank[slot];
            hits_seen++;
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!found && !frame_live[i]) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                // cold fill of the lowest empty frame: every live frame ages
                limit = 256;
            end else begin
                // evict the oldest; ties go to the lowest index
                for (int i = 1; i < n; i++) begin
                    if (frame_rank[i] > frame_rank[slot])
                        slot = i;
                end
                o.evicted_valid = 1'b1;
                o.evicted_page  = frame_page[slot];
                limit           = frame_rank[slot];
                evictions_seen++;
            end
            frame_page[slot] = pg;
            frame_live[slot] = 1'b1;
            if (fault_total != '1)
                fault_total++;
        end
        for (int i = 0; i < n; i++) begin
            if (frame_live[i] && i != slot && frame_rank[i] < limit)
                frame_rank[i]++;
        end
        frame_rank[slot] = '0;
        o.frame_slot  = t_slot'(slot);
        o.fault_count = fault_total;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer references from the queue, record accepted beats
    // ------------------------------------------------------------------
    int src_gap;

    always @(posedge clk) begin : ref_driver
        if (!rst_n) begin
            ref_ch.valid <= 1'b0;
            src_gap      <= 0;
            set_frame_count(CFG_RESET);
            fault_total  = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                set_frame_count(cfg_ch.frames_in_use);
                cfg_writes++;
            end
            if (ref_ch.valid && ref_ch.ready)
                expected_outcomes.push_back(lookup_and_replace(ref_ch.page_number));

            // hold a beat the unit has not taken yet
            if (!(ref_ch.valid && !ref_ch.ready)) begin
                if (src_gap > 0) begin
                    src_gap      <= src_gap - 1;
                    ref_ch.valid <= 1'b0;
                end else if ($urandom_range(0, 99) < src_idle_pct) begin
                    src_gap      <= $urandom_range(1, 9) - 1;
                    ref_ch.valid <= 1'b0;
                end else if (refs_to_send.size() != 0) begin
                    ref_ch.valid       <= 1'b1;
                    ref_ch.page_number <= refs_to_send.pop_front();
                end else begin
                    ref_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat, then pick the next ready level
    // ------------------------------------------------------------------
    int sink_gap;
    int stall_left;
    int long_stall_done;

    always @(posedge clk) begin : res_monitor
        t_ref_outcome want;
        if (!rst_n) begin
            res_ch.ready    <= 1'b0;
            sink_gap        <= 0;
            stall_left      <= 0;
            long_stall_done <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result with no reference pending", 0, 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (res_ch.hit !== want.hit)
                        report_mismatch("hit", res_ch.hit, want.hit);
                    if (res_ch.frame_slot !== want.frame_slot)
                        report_mismatch("frame_slot", res_ch.frame_slot, want.frame_slot);
                    if (res_ch.evicted_valid !== want.evicted_valid)
                        report_mismatch("evicted_valid", res_ch.evicted_valid,
                                        want.evicted_valid);
                    if (res_ch.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", res_ch.evicted_page,
                                        want.evicted_page);
                    if (res_ch.fault_count !== want.fault_count)
                        report_mismatch("fault_count", res_ch.fault_count,
                                        want.fault_count);
                end
            end

            // a long hold-off wins over the short random bursts
            if (long_stall_reqs != long_stall_done) begin
                long_stall_done <= long_stall_reqs;
                stall_left      <= LONG_STALL - 1;
                res_ch.ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap     <= sink_gap - 1;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap     <= $urandom_range(1, 9) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((ref_ch.valid && ref_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Wait until the unit is empty, then let the pipeline settle
    task automatic drain();
        do
            @(negedge clk);
        while (refs_to_send.size() != 0 || ref_ch.valid || expected_outcomes.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write frames_in_use; call only while the unit is empty
    task automatic write_frame_count(input t_cfg setting);
        @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.frames_in_use <= setting;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Queue a reference string drawn mostly from a small working set so that
    // hits, fills and evictions all come up; the rest repeats or goes wide
    task automatic push_random(input int count, input int pool_size);
        t_page pool [$];
        t_page pg;
        int    pick;
        for (int k = 0; k < pool_size; k++)
            pool.push_back(t_page'($urandom));
        pg = pool[0];
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                pg = pool[$urandom_range(0, pool_size - 1)];
            else if (pick >= 82)
                pg = t_page'($urandom);
            refs_to_send.push_back(pg);
        end
    endtask

    initial begin : stimulus
        int len;
        int eff;
        cfg_ch.valid         = 1'b0;
        cfg_ch.frames_in_use = CFG_RESET;
        rst_n                = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Eight frames after reset: cold fills with extreme page numbers, hits on
        // a middle frame and the second-oldest frame, then two evictions in a row
        refs_to_send = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                         16'h0001, 16'h0002, 16'h0003, 16'h0004,
                         16'h5555, 16'hFFFF, 16'h1234, 16'h0000};
        drain();

        // One frame: a fill, a hit, then a miss that evicts the single resident page
        write_frame_count(4'd1);
        refs_to_send = '{16'h0007, 16'h0007, 16'h0008};
        drain();

        // Zero acts as one frame
        write_frame_count(4'd0);
        refs_to_send = '{16'h0003, 16'h0003, 16'h8000};
        drain();

        // Above the frame count clamps to eight; earlier pages were flushed
        write_frame_count(4'd15);
        refs_to_send = '{16'h0005, 16'h0006, 16'h0005};
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_frame_count(SWEEP[ph]);
            // leave some phases and the last one free of idling
            if (ph == PHASES - 1 || ph % 4 == 2) begin
                src_idle_pct  <= 0;
                sink_idle_pct <= 0;
            end else begin
                src_idle_pct  <= $urandom_range(5, 35);
                sink_idle_pct <= $urandom_range(5, 35);
            end
            len = $urandom_range(100, 150);
            eff = active_count(SWEEP[ph]);
            if (ph == 4) begin
                // fill the queue, then stall the receiver so i_ref backs up
                push_random(len, eff + 2);
                long_stall_reqs <= long_stall_reqs + 1;
            end else if (ph == 6) begin
                // sender pauses mid-phase until every outcome is back
                push_random(len / 2, eff + 3);
                drain();
                push_random(len - len / 2, eff + 3);
            end else begin
                push_random(len, eff + $urandom_range(0, 4));
            end
            drain();
        end

        if (expected_outcomes.size() != 0)
            report_mismatch("outcomes never returned", 0, expected_outcomes.size());

        $display("Covered %0d references (%0d hits, %0d evictions) over %0d frame-count writes",
                 results_seen, hits_seen, evictions_seen, cfg_writes);
        $display("Final fault total %0d, %0d mismatches", fault_total, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
